// ----- sv/dmc_pkg.sv -----
// dmc_pkg: shared types for the direct-mapped write-back cache unit
// used by dmc_front, dmc_back and the top level; no dependencies
package dmc_pkg;

	typedef struct packed {
		logic        is_write;
		logic [29:0] word_addr;
		logic [31:0] wdata;
		logic        clear;
		logic        err;
	} item_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_stat_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_WB,
		ST_FILL,
		ST_ACCESS,
		ST_RESP
	} back_state_t;

	localparam int unsigned LAT_W = 10;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MEM_RD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEM_WR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CACHE_RD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CACHE_WR = 3'd3;

endpackage

// ----- sv/direct_mapped_writeback_cache_unit.sv -----
// direct_mapped_writeback_cache_unit: top level of the write-back cache unit
// depends on dmc_pkg, dmc_front and dmc_back
//
// After reset the unit sweeps the backing memory to zero, one word per cycle,
// with busy high. A command beat is taken when start is high and busy is low;
// up to two beats queue ahead of the sequencer. The sequencer takes a hit
// through lookup to its response and a range error straight to its response.
// A miss adds a refill of the line from the backing memory and the word access
// behind it and, for a dirty victim, a write-back to the backing memory before
// the refill. Results come out in order, one cycle each on done, and cannot be
// held off.
module direct_mapped_writeback_cache_unit #(
	parameter int unsigned OFFSET_BITS = 6,
	parameter int unsigned INDEX_BITS = 8,
	parameter int unsigned MEM_BYTES = 262144
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [dmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dmc_pkg::LAT_W-1:0]     cfg_data,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic [31:0]                   byte_address,
	input  logic [31:0]                   write_data,
	input  logic                          clear_time,
	output logic                          done,
	output logic [31:0]                   read_data,
	output logic                          hit,
	output logic                          wrote_back,
	output logic                          range_error,
	output logic [31:0]                   elapsed_time
);
	import dmc_pkg::*;

	back_stat_t stat;
	logic       head_valid;
	item_t      head;

	dmc_front #(
		.OFFSET_BITS(OFFSET_BITS),
		.MEM_BYTES(MEM_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.byte_address(byte_address),
		.write_data(write_data),
		.clear_time(clear_time),
		.stat(stat),
		.busy(busy),
		.head_valid(head_valid),
		.head(head)
	);

	dmc_back #(
		.OFFSET_BITS(OFFSET_BITS),
		.INDEX_BITS(INDEX_BITS),
		.MEM_BYTES(MEM_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.head_valid(head_valid),
		.head(head),
		.stat(stat),
		.done(done),
		.read_data(read_data),
		.hit(hit),
		.wrote_back(wrote_back),
		.range_error(range_error),
		.elapsed_time(elapsed_time)
	);

endmodule

// ----- sv/dmc_front.sv -----
// dmc_front: accepts command beats, flags out-of-range lines, two-entry queue
// depends on dmc_pkg
module dmc_front #(
	parameter int unsigned OFFSET_BITS = 6,
	parameter int unsigned MEM_BYTES = 262144
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                cmd,
	input  logic [31:0]         byte_address,
	input  logic [31:0]         write_data,
	input  logic                clear_time,
	input  dmc_pkg::back_stat_t stat,
	output logic                busy,
	output logic                head_valid,
	output dmc_pkg::item_t      head
);
	import dmc_pkg::*;

	localparam logic [32:0] LINE_BYTES = 33'(1) << OFFSET_BITS;
	localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);

	item_t       entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        accept;
	logic [32:0] line_end;
	item_t       new_item;

	assign busy = (count_q == 2'd2) || stat.clearing;
	assign accept = start && !busy;
	assign head_valid = (count_q != 2'd0);
	assign head = entry_q[rd_ptr_q];

	always_comb begin
		line_end = {1'b0, byte_address[31:OFFSET_BITS], {OFFSET_BITS{1'b0}}} + LINE_BYTES;
		new_item.is_write = cmd;
		new_item.word_addr = byte_address[31:2];
		new_item.wdata = write_data;
		new_item.clear = clear_time;
		new_item.err = (line_end > MEM_LIMIT);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (stat.pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(accept) - 2'(stat.pop);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd2 |-> !accept)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.pop |-> count_q != 2'd0)
		else $error("queue popped while empty");
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |=> count_q == $past(count_q))
		else $error("queue moved during clearing pass");
`endif

endmodule

// ----- sv/dmc_back.sv -----
// dmc_back: tag/line stores, backing memory, miss sequencer and time accumulator
// depends on dmc_pkg; fed from the dmc_front queue
module dmc_back #(
	parameter int unsigned OFFSET_BITS = 6,
	parameter int unsigned INDEX_BITS = 8,
	parameter int unsigned MEM_BYTES = 262144
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [dmc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dmc_pkg::LAT_W-1:0]       cfg_data,
	input  logic                            head_valid,
	input  dmc_pkg::item_t                  head,
	output dmc_pkg::back_stat_t             stat,
	output logic                            done,
	output logic [31:0]                     read_data,
	output logic                            hit,
	output logic                            wrote_back,
	output logic                            range_error,
	output logic [31:0]                     elapsed_time
);
	import dmc_pkg::*;

	localparam int unsigned LWB = OFFSET_BITS - 2;
	localparam int unsigned LW = 1 << LWB;
	localparam int unsigned CW = LWB + 1;
	localparam int unsigned TAGW = 32 - OFFSET_BITS - INDEX_BITS;
	localparam int unsigned LINES = 1 << INDEX_BITS;
	localparam int unsigned LA = INDEX_BITS + LWB;
	localparam int unsigned MEM_WORDS = MEM_BYTES / 4;
	localparam int unsigned MA = $clog2(MEM_WORDS);
	localparam logic [CW-1:0] CNT_END = CW'(LW);
	localparam logic [MA-1:0] CLR_END = MA'(MEM_WORDS - 1);

	back_state_t state_q, state_d;

	logic [TAGW-1:0]  tag_mem [LINES];
	logic [31:0]      line_mem [LINES * LW];
	logic [31:0]      back_mem [MEM_WORDS];

	logic [TAGW-1:0]  tag_rd;
	logic [31:0]      lw_rd;
	logic [31:0]      bm_rd;
	logic [LINES-1:0] valid_q;
	logic [LINES-1:0] dirty_q;
	item_t            item_q;
	logic [CW-1:0]    cnt_q;
	logic [MA-1:0]    clr_q;
	logic [31:0]      time_q;
	logic             hit_q;
	logic             wb_q;
	logic [LAT_W-1:0] mem_rd_lat_q;
	logic [LAT_W-1:0] mem_wr_lat_q;
	logic [LAT_W-1:0] cache_rd_lat_q;
	logic [LAT_W-1:0] cache_wr_lat_q;
	logic             done_q;
	logic [31:0]      read_data_q;
	logic             hit_out_q;
	logic             wb_out_q;
	logic             err_out_q;

	logic [INDEX_BITS-1:0] idx;
	logic [INDEX_BITS-1:0] head_idx;
	logic [INDEX_BITS-1:0] tag_raddr;
	logic [TAGW-1:0]       tag;
	logic [LWB-1:0]        woff;
	logic [LWB-1:0]        cm1;
	logic                  lk_hit;
	logic                  pop;
	logic                  acc;
	logic                  lw_we;
	logic [LA-1:0]         lw_waddr;
	logic [31:0]           lw_wdata;
	logic [LA-1:0]         lw_raddr;
	logic                  bm_we;
	logic [MA-1:0]         bm_waddr;
	logic [31:0]           bm_wdata;
	logic [MA-1:0]         bm_raddr;
	logic [29:0]           victim_w;
	logic [29:0]           fill_w;

	assign idx = item_q.word_addr[LWB +: INDEX_BITS];
	assign head_idx = head.word_addr[LWB +: INDEX_BITS];
	assign tag = item_q.word_addr[29 -: TAGW];
	assign woff = item_q.word_addr[LWB-1:0];
	assign cm1 = LWB'(cnt_q - CW'(1));
	assign lk_hit = valid_q[idx] && (tag_rd == tag);
	assign tag_raddr = (state_q == ST_IDLE) ? head_idx : idx;
	assign victim_w = {tag_rd, idx, cm1};
	assign fill_w = {item_q.word_addr[29:LWB], cnt_q[LWB-1:0]};

	assign stat.pop = pop;
	assign stat.clearing = (state_q == ST_CLEAR);

	assign done = done_q;
	assign read_data = read_data_q;
	assign hit = hit_out_q;
	assign wrote_back = wb_out_q;
	assign range_error = err_out_q;
	assign elapsed_time = time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		acc = 1'b0;
		lw_we = 1'b0;
		lw_waddr = {idx, woff};
		lw_wdata = item_q.wdata;
		lw_raddr = {idx, woff};
		bm_we = 1'b0;
		bm_waddr = clr_q;
		bm_wdata = '0;
		bm_raddr = fill_w[MA-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				bm_we = 1'b1;
				if (clr_q == CLR_END) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (head_valid) begin
					pop = 1'b1;
					state_d = head.err ? ST_RESP : ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (lk_hit) begin
					acc = 1'b1;
					state_d = ST_RESP;
				end else if (valid_q[idx] && dirty_q[idx]) begin
					state_d = ST_WB;
				end else begin
					state_d = ST_FILL;
				end
			end
			ST_WB: begin
				lw_raddr = {idx, cnt_q[LWB-1:0]};
				bm_we = (cnt_q != '0);
				bm_waddr = victim_w[MA-1:0];
				bm_wdata = lw_rd;
				if (cnt_q == CNT_END) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				lw_we = (cnt_q != '0);
				lw_waddr = {idx, cm1};
				lw_wdata = bm_rd;
				if (cnt_q == CNT_END) begin
					state_d = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				acc = 1'b1;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (acc && item_q.is_write) begin
			lw_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		tag_rd <= tag_mem[tag_raddr];
		if (state_q == ST_FILL && cnt_q == CNT_END) begin
			tag_mem[idx] <= tag;
		end
	end

	always_ff @(posedge clk) begin
		lw_rd <= line_mem[lw_raddr];
		if (lw_we) begin
			line_mem[lw_waddr] <= lw_wdata;
		end
	end

	always_ff @(posedge clk) begin
		bm_rd <= back_mem[bm_raddr];
		if (bm_we) begin
			back_mem[bm_waddr] <= bm_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_rd_lat_q <= LAT_W'(100);
			mem_wr_lat_q <= LAT_W'(50);
			cache_rd_lat_q <= LAT_W'(1);
			cache_wr_lat_q <= LAT_W'(1);
		end else if (cfg_write) begin
			if (cfg_index == REG_MEM_RD) begin
				mem_rd_lat_q <= cfg_data;
			end
			if (cfg_index == REG_MEM_WR) begin
				mem_wr_lat_q <= cfg_data;
			end
			if (cfg_index == REG_CACHE_RD) begin
				cache_rd_lat_q <= cfg_data;
			end
			if (cfg_index == REG_CACHE_WR) begin
				cache_wr_lat_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			cnt_q <= '0;
			clr_q <= '0;
			time_q <= '0;
			hit_q <= 1'b0;
			wb_q <= 1'b0;
			done_q <= 1'b0;
			read_data_q <= '0;
			hit_out_q <= 1'b0;
			wb_out_q <= 1'b0;
			err_out_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + MA'(1);
			end
			if (pop) begin
				hit_q <= 1'b0;
				wb_q <= 1'b0;
				if (head.clear) begin
					time_q <= '0;
				end
			end
			if (state_q == ST_LOOKUP) begin
				hit_q <= lk_hit;
				wb_q <= !lk_hit && valid_q[idx] && dirty_q[idx];
				cnt_q <= '0;
			end
			if (state_q == ST_WB || state_q == ST_FILL) begin
				cnt_q <= (cnt_q == CNT_END) ? '0 : cnt_q + CW'(1);
			end
			if (state_q == ST_WB && cnt_q == CNT_END) begin
				time_q <= time_q + 32'(mem_wr_lat_q);
			end
			if (state_q == ST_FILL && cnt_q == CNT_END) begin
				time_q <= time_q + 32'(mem_rd_lat_q);
				valid_q[idx] <= 1'b1;
				dirty_q[idx] <= 1'b0;
			end
			if (acc) begin
				if (item_q.is_write) begin
					dirty_q[idx] <= 1'b1;
					time_q <= time_q + 32'(cache_wr_lat_q);
				end else begin
					time_q <= time_q + 32'(cache_rd_lat_q);
				end
			end
			if (state_q == ST_RESP) begin
				done_q <= 1'b1;
				read_data_q <= (item_q.err || item_q.is_write) ? '0 : lw_rd;
				hit_out_q <= hit_q;
				wb_out_q <= wb_q;
				err_out_q <= item_q.err;
			end
		end
	end

`ifndef ASSERT_OFF
	a_done_after_resp: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_RESP))
		else $error("result beat without response state");
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && err_out_q |-> !hit_out_q && !wb_out_q && read_data_q == '0)
		else $error("range error result carries access flags");
	a_wb_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(hit_out_q && wb_out_q))
		else $error("write-back reported on a hit");
	a_wb_to_fill: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WB |=> state_q == ST_WB || state_q == ST_FILL)
		else $error("write-back left without refill");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == ST_LOOKUP || state_q == ST_RESP)
		else $error("popped item not taken up");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking testbench for direct_mapped_writeback_cache_unit
// a scoreboard class predicts each result beat from its own model of the cache and backing
// memory; depends on dmc_pkg and the unit's rtl
module tb;
	import dmc_pkg::*;

	localparam int unsigned LINES = 256;
	localparam int unsigned WORDS_PER_LINE = 16;
	localparam int unsigned MEM_WORDS = 65536;
	localparam longint unsigned MEM_SIZE = 262144;
	localparam int unsigned CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [31:0] rdata;
		logic        hit;
		logic        wb;
		logic        err;
		logic [31:0] elapsed;
	} cache_result_t;

	class cache_scoreboard;
		logic [17:0]   tags [LINES];
		bit            valid [LINES];
		bit            dirty [LINES];
		logic [31:0]   line_data [LINES*WORDS_PER_LINE];
		logic [31:0]   backing [MEM_WORDS];
		logic [31:0]   total;
		logic [9:0]    lat [4];
		cache_result_t pending_results [$];
		int            fails;
		int            n_beats, n_hits, n_wbs, n_errs;

		function new();
			for (int i = 0; i < LINES; i++) begin
				valid[i] = 0;
				dirty[i] = 0;
			end
			for (int i = 0; i < MEM_WORDS; i++)
				backing[i] = '0;
			total = '0;
			lat[REG_MEM_RD] = 10'd100;
			lat[REG_MEM_WR] = 10'd50;
			lat[REG_CACHE_RD] = 10'd1;
			lat[REG_CACHE_WR] = 10'd1;
			fails = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LAT_W-1:0] val);
			if (idx <= REG_CACHE_WR)
				lat[idx] = val;
		endfunction

		function void note_command(logic wr, logic [31:0] addr, logic [31:0] wdata, logic clr);
			cache_result_t r;
			logic [31:0]   base, vbase;
			logic [17:0]   tg;
			logic [7:0]    idx;
			logic [3:0]    woff;
			int unsigned   slot;
			r = '{32'd0, 1'b0, 1'b0, 1'b0, 32'd0};
			if (clr)
				total = '0;
			addr[1:0] = 2'b00;
			base = {addr[31:6], 6'd0};
			if (longint'(base) + 64 > MEM_SIZE) begin
				r.err = 1'b1;
			end else begin
				tg = addr[31:14];
				idx = addr[13:6];
				woff = addr[5:2];
				slot = idx * WORDS_PER_LINE;
				if (valid[idx] && tags[idx] == tg) begin
					r.hit = 1'b1;
				end else begin
					if (valid[idx] && dirty[idx]) begin
						vbase = {tags[idx], idx, 6'd0};
						for (int k = 0; k < WORDS_PER_LINE; k++)
							if ((vbase >> 2) + k < MEM_WORDS)
								backing[(vbase >> 2) + k] = line_data[slot + k];
						total += lat[REG_MEM_WR];
						r.wb = 1'b1;
					end
					for (int k = 0; k < WORDS_PER_LINE; k++)
						line_data[slot + k] = backing[(base >> 2) + k];
					total += lat[REG_MEM_RD];
					valid[idx] = 1;
					dirty[idx] = 0;
					tags[idx] = tg;
				end
				if (wr) begin
					line_data[slot + woff] = wdata;
					dirty[idx] = 1;
					total += lat[REG_CACHE_WR];
				end else begin
					r.rdata = line_data[slot + woff];
					total += lat[REG_CACHE_RD];
				end
			end
			r.elapsed = total;
			pending_results.push_back(r);
		endfunction

		function void check_result(cache_result_t got);
			cache_result_t want;
			if (pending_results.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected result beat at %0t", $realtime);
				return;
			end
			want = pending_results.pop_front();
			n_beats++;
			n_hits += want.hit;
			n_wbs += want.wb;
			n_errs += want.err;
			if (got.rdata !== want.rdata || got.hit !== want.hit || got.wb !== want.wb ||
			    got.err !== want.err || got.elapsed !== want.elapsed) begin
				fails++;
				if (fails <= 10)
					$display({"mismatch beat %0d: exp rd=%h hit=%b wb=%b err=%b t=%h,",
						" got rd=%h hit=%b wb=%b err=%b t=%h"},
						n_beats, want.rdata, want.hit, want.wb, want.err, want.elapsed,
						got.rdata, got.hit, got.wb, got.err, got.elapsed);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LAT_W-1:0]     cfg_data;
	logic                 start;
	logic                 busy;
	logic                 cmd;
	logic [31:0]          byte_address;
	logic [31:0]          write_data;
	logic                 clear_time;
	logic                 done;
	logic [31:0]          read_data;
	logic                 hit;
	logic                 wrote_back;
	logic                 range_error;
	logic [31:0]          elapsed_time;

	cache_scoreboard sb;
	int unsigned     cycles;
	logic [7:0]      hot_lines [4];

	direct_mapped_writeback_cache_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.start(start), .busy(busy),
		.cmd(cmd), .byte_address(byte_address), .write_data(write_data),
		.clear_time(clear_time),
		.done(done), .read_data(read_data), .hit(hit), .wrote_back(wrote_back),
		.range_error(range_error), .elapsed_time(elapsed_time)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n && done)
			sb.check_result('{read_data, hit, wrote_back, range_error, elapsed_time});
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// called at a rising edge, returns at the edge that took the beat, or after a random idle gap behind it
	task automatic send(logic c, logic [31:0] a, logic [31:0] d, logic cl);
		int unsigned gap;
		start <= 1'b1;
		cmd <= c;
		byte_address <= a;
		write_data <= d;
		clear_time <= cl;
		forever begin
			@(negedge clk);
			if (!busy)
				break;
			@(posedge clk);
		end
		@(posedge clk);
		sb.note_command(c, a, d, cl);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_regs(logic [LAT_W-1:0] v0, logic [LAT_W-1:0] v1,
	                          logic [LAT_W-1:0] v2, logic [LAT_W-1:0] v3);
		logic [LAT_W-1:0] vals [4];
		vals = '{v0, v1, v2, v3};
		for (int i = 0; i < 4; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			sb.set_reg(CFG_IDX_W'(i), vals[i]);
			@(posedge clk);
		end
		// indexes past the last register are ignored
		cfg_index <= CFG_IDX_W'($urandom_range(4, 7));
		cfg_data <= LAT_W'($urandom);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic logic [31:0] pick_address();
		if ($urandom_range(0, 99) < 85)
			return {16'd0, 2'($urandom_range(0, 3)), hot_lines[2'($urandom_range(0, 3))],
			        6'($urandom)};
		return $urandom;
	endfunction

	task automatic random_beats(int unsigned count);
		for (int i = 0; i < count; i++)
			send(1'($urandom_range(0, 1)), pick_address(), $urandom,
			     $urandom_range(0, 15) == 0);
	endtask

	initial begin
		sb = new();
		cycles = 0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		start = 1'b0;
		cmd = 1'b0;
		byte_address = '0;
		write_data = '0;
		clear_time = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// wait out the memory clearing sweep
		do @(negedge clk); while (busy);
		@(posedge clk);

		write_regs(10'd100, 10'd50, 10'd1, 10'd1);
		send(1'b0, 32'h0000_0000, 32'h0, 1'b0);
		send(1'b1, 32'h0000_0004, 32'hFFFF_FFFF, 1'b0);
		send(1'b0, 32'h0000_0007, 32'h0, 1'b0);
		send(1'b1, 32'h0000_4001, 32'hA5A5_5A5A, 1'b0);
		send(1'b0, 32'h0000_0004, 32'h0, 1'b1);
		send(1'b0, 32'h0000_4000, 32'h0, 1'b0);
		send(1'b1, 32'h0003_FFFC, 32'h8000_0001, 1'b0);
		send(1'b0, 32'h0003_FFFF, 32'h0, 1'b0);
		send(1'b1, 32'h0000_3FFC, 32'h1234_5678, 1'b0);
		send(1'b0, 32'h0004_0000, 32'h0, 1'b0);
		send(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send(1'b0, 32'hFFFF_FFC0, 32'h0, 1'b0);
		send(1'b0, 32'h0003_FFC0, 32'h0, 1'b0);
		send(1'b0, 32'h0002_3FFC, 32'h0, 1'b0);
		send(1'b0, 32'h0000_3FFC, 32'h0, 1'b0);
		send(1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1);
		send(1'b0, 32'h0001_0000, 32'h0, 1'b0);
		send(1'b0, 32'h0000_0000, 32'h0, 1'b0);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_regs(10'd0, 10'd0, 10'd0, 10'd0);
				1: write_regs(10'd1023, 10'd1023, 10'd1023, 10'd1023);
				2: write_regs(10'd100, 10'd50, 10'd1, 10'd1);
				default: write_regs(LAT_W'($urandom), LAT_W'($urandom),
				                    LAT_W'($urandom), LAT_W'($urandom));
			endcase
			for (int i = 0; i < 4; i++)
				hot_lines[i] = (ph == 1 && i == 0) ? 8'hFF : 8'($urandom);
			random_beats(190);
			drain();
		end

		$display("%0d result beats checked: %0d hits, %0d write-backs, %0d range errors",
			sb.n_beats, sb.n_hits, sb.n_wbs, sb.n_errs);
		$display("latency settings covered zero, maximum, reset and random values");
		if (sb.fails == 0 && sb.pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// ----- filelist.f -----
sv/dmc_pkg.sv
sv/dmc_front.sv
sv/dmc_back.sv
sv/direct_mapped_writeback_cache_unit.sv
tb/tb.sv
